[hw/rtl/natural_order_string_compare_core_assert.svh]
// Assertion macros for the natural order string compare core checker.
// Expects signals named clk and rst_n in the scope of use.
`ifndef NATURAL_ORDER_STRING_COMPARE_CORE_ASSERT_SVH
`define NATURAL_ORDER_STRING_COMPARE_CORE_ASSERT_SVH

// Clocked property, disabled during reset.
`define NOSC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("nosc checker: property failed");

// Antecedent in one cycle implies consequent in the next.
`define NOSC_ASSERT_NEXT(lbl, ante, cons) \
  `NOSC_ASSERT(lbl, (ante) |=> (cons))

`endif

[hw/rtl/nosc_pkg.sv]
// Shared types, command codes and character class helpers for the
// natural order string compare core. No dependencies.
`default_nettype none

package nosc_pkg;

  localparam logic [1:0] CMD_LEFT  = 2'd0;
  localparam logic [1:0] CMD_RIGHT = 2'd1;
  localparam logic [1:0] CMD_CMP   = 2'd2;

  localparam logic [7:0] CH_ZERO = 8'h30;

  typedef logic [1:0] rank_t;
  localparam rank_t RANK_OTHER = 2'd0;
  localparam rank_t RANK_PUNCT = 2'd1;
  localparam rank_t RANK_DIGIT = 2'd2;
  localparam rank_t RANK_ALPHA = 2'd3;

  typedef struct packed {
    logic append;
    logic clear;
  } buf_ctl_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic rank_t rank_of(input logic [7:0] c);
    rank_t r;
    if (is_digit(c)) r = RANK_DIGIT;
    else if (is_alpha(c)) r = RANK_ALPHA;
    else if ((c >= 8'h21) && (c <= 8'h7E)) r = RANK_PUNCT;
    else r = RANK_OTHER;
    return r;
  endfunction

  function automatic logic [7:0] upper_char(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) ? (c - 8'h20) : c;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/nosc_if.sv]
// Valid/ready channel interfaces for the request and result sides of the
// natural order string compare core. No dependencies.
`default_nettype none

interface nosc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] char_code;

  modport source (output valid, cmd, char_code, input ready);
  modport sink   (input valid, cmd, char_code, output ready);
endinterface

interface nosc_out_if;
  logic valid;
  logic ready;
  logic left_is_less;
  logic bad_char_seen;
  logic overflowed;

  modport source (output valid, left_is_less, bad_char_seen, overflowed, input ready);
  modport sink   (input valid, left_is_less, bad_char_seen, overflowed, output ready);
endinterface

`default_nettype wire

[hw/rtl/nosc_strbuf.sv]
// One string buffer: byte memory with fill count, append port and a
// registered read port. Depends on nosc_pkg.
`default_nettype none

module nosc_strbuf #(
  parameter int MAX_LEN = 256,
  localparam int CW = $clog2(MAX_LEN + 1),
  localparam int AW = $clog2(MAX_LEN)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  nosc_pkg::buf_ctl_t ctl,
  input  logic [7:0]        wr_char,
  input  logic [CW-1:0]     rd_idx,
  output logic [7:0]        rd_data_r,
  output logic [CW-1:0]     count_r,
  output logic              drop
);
  import nosc_pkg::*;

  logic [7:0]    mem [MAX_LEN];
  logic          full;
  logic          wr_en;
  logic [CW-1:0] count_nxt;

  assign full  = (count_r == CW'(MAX_LEN));
  assign wr_en = ctl.append && !full;
  assign drop  = ctl.append && full;

  always_comb begin
    count_nxt = count_r;
    if (ctl.clear) begin
      count_nxt = '0;
    end else if (wr_en) begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[AW-1:0]] <= wr_char;
    end
    rd_data_r <= mem[rd_idx[AW-1:0]];
  end

endmodule

`default_nettype wire

[hw/rtl/natural_order_string_compare_core.sv]
// Channel    | Dir | Payload                                   | Accept
// in_ch      | in  | cmd[1:0], char_code[7:0]                  | valid && ready
// out_ch     | out | left_is_less, bad_char_seen, overflowed   | valid && ready
//
// A compare request walks both buffers with one shared read port each and a
// small sequencer: S_CHAR steps over non-digit pairs and sees a buffer end,
// each digit run passes through S_ZSKIP (leading zeros) and then S_DSCAN
// (significant digits), and S_FIN posts the result; in_ch.ready is low
// meanwhile. Reset clears counts, the overflow flag, output valid and the
// sequencer; buffer contents stay undefined until written. A stalled result
// holds in the output register while appends go on; the next compare posts only
// once that slot is free. Depends on nosc_pkg, nosc_if and nosc_strbuf.
`default_nettype none

module natural_order_string_compare_core #(
  parameter int MAX_LEN = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  nosc_in_if.sink     in_ch,
  nosc_out_if.source  out_ch
);
  import nosc_pkg::*;

  localparam int CW = $clog2(MAX_LEN + 1);

  typedef enum logic [2:0] {S_IDLE, S_CHAR, S_ZSKIP, S_DSCAN, S_FIN} state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] li_r, li_nxt, ri_r, ri_nxt;
  logic          bad_r, bad_nxt;
  logic          zd_set_r, zd_set_nxt, zd_less_r, zd_less_nxt;
  logic          dd_set_r, dd_set_nxt, dd_less_r, dd_less_nxt;
  logic          res_less_r, res_less_nxt;
  logic          ovf_r, ovf_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_less_r, out_less_nxt;
  logic          out_bad_r, out_bad_nxt;
  logic          out_ovf_r, out_ovf_nxt;

  buf_ctl_t      l_ctl, r_ctl;
  logic [7:0]    ldat, rdat;
  logic [CW-1:0] ln, rn;
  logic          l_drop, r_drop;

  logic          in_fire;
  logic          l_has, r_has;
  logic [CW-1:0] l_rem, r_rem;
  logic          l_zero, r_zero, l_dig, r_dig;
  rank_t         ra, rb;
  logic [7:0]    ua, ub;

  nosc_strbuf #(.MAX_LEN(MAX_LEN)) u_left (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (l_ctl),
    .wr_char  (in_ch.char_code),
    .rd_idx   (li_nxt),
    .rd_data_r(ldat),
    .count_r  (ln),
    .drop     (l_drop)
  );

  nosc_strbuf #(.MAX_LEN(MAX_LEN)) u_right (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (r_ctl),
    .wr_char  (in_ch.char_code),
    .rd_idx   (ri_nxt),
    .rd_data_r(rdat),
    .count_r  (rn),
    .drop     (r_drop)
  );

  assign in_ch.ready          = (state_r == S_IDLE);
  assign in_fire              = in_ch.valid && in_ch.ready;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.left_is_less  = out_less_r;
  assign out_ch.bad_char_seen = out_bad_r;
  assign out_ch.overflowed    = out_ovf_r;

  assign l_has  = (li_r < ln);
  assign r_has  = (ri_r < rn);
  assign l_rem  = ln - li_r;
  assign r_rem  = rn - ri_r;
  assign l_zero = l_has && (ldat == CH_ZERO);
  assign r_zero = r_has && (rdat == CH_ZERO);
  assign l_dig  = l_has && is_digit(ldat);
  assign r_dig  = r_has && is_digit(rdat);
  assign ra     = rank_of(ldat);
  assign rb     = rank_of(rdat);
  assign ua     = upper_char(ldat);
  assign ub     = upper_char(rdat);

  always_comb begin
    state_nxt     = state_r;
    li_nxt        = li_r;
    ri_nxt        = ri_r;
    bad_nxt       = bad_r;
    zd_set_nxt    = zd_set_r;
    zd_less_nxt   = zd_less_r;
    dd_set_nxt    = dd_set_r;
    dd_less_nxt   = dd_less_r;
    res_less_nxt  = res_less_r;
    ovf_nxt       = ovf_r | l_drop | r_drop;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_less_nxt  = out_less_r;
    out_bad_nxt   = out_bad_r;
    out_ovf_nxt   = out_ovf_r;
    l_ctl         = '0;
    r_ctl         = '0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_ch.cmd)
            CMD_LEFT:  l_ctl.append = 1'b1;
            CMD_RIGHT: r_ctl.append = 1'b1;
            CMD_CMP: begin
              li_nxt     = '0;
              ri_nxt     = '0;
              bad_nxt    = 1'b0;
              zd_set_nxt = 1'b0;
              state_nxt  = S_CHAR;
            end
            default: ;
          endcase
        end
      end

      S_CHAR: begin
        if (!(l_has && r_has)) begin
          // shorter remainder wins, then the first leading-zero difference
          if (l_rem != r_rem) begin
            res_less_nxt = (l_rem < r_rem);
          end else begin
            res_less_nxt = zd_set_r && zd_less_r;
          end
          state_nxt = S_FIN;
        end else if (is_digit(ldat) && is_digit(rdat)) begin
          dd_set_nxt = 1'b0;
          state_nxt  = S_ZSKIP;
        end else begin
          if ((ra == RANK_OTHER) || (rb == RANK_OTHER)) begin
            bad_nxt = 1'b1;
          end
          if (ra != rb) begin
            res_less_nxt = (ra < rb);
            state_nxt    = S_FIN;
          end else if (ua != ub) begin
            res_less_nxt = (ua < ub);
            state_nxt    = S_FIN;
          end else begin
            li_nxt = li_r + 1'b1;
            ri_nxt = ri_r + 1'b1;
          end
        end
      end

      S_ZSKIP: begin
        // side still on a zero after the other stopped has more zeros
        if (l_zero && r_zero) begin
          li_nxt = li_r + 1'b1;
          ri_nxt = ri_r + 1'b1;
        end else if (l_zero) begin
          if (!zd_set_r) begin
            zd_set_nxt  = 1'b1;
            zd_less_nxt = 1'b1;
          end
          li_nxt = li_r + 1'b1;
        end else if (r_zero) begin
          if (!zd_set_r) begin
            zd_set_nxt  = 1'b1;
            zd_less_nxt = 1'b0;
          end
          ri_nxt = ri_r + 1'b1;
        end else begin
          state_nxt = S_DSCAN;
        end
      end

      S_DSCAN: begin
        // lockstep scan: length decides first, then the first differing digit
        if (l_dig && r_dig) begin
          if (!dd_set_r && (ldat != rdat)) begin
            dd_set_nxt  = 1'b1;
            dd_less_nxt = (ldat < rdat);
          end
          li_nxt = li_r + 1'b1;
          ri_nxt = ri_r + 1'b1;
        end else if (l_dig) begin
          res_less_nxt = 1'b0;
          state_nxt    = S_FIN;
        end else if (r_dig) begin
          res_less_nxt = 1'b1;
          state_nxt    = S_FIN;
        end else if (dd_set_r) begin
          res_less_nxt = dd_less_r;
          state_nxt    = S_FIN;
        end else begin
          state_nxt = S_CHAR;
        end
      end

      S_FIN: begin
        // hold until the output slot frees, then post and clear buffers
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_less_nxt  = res_less_r;
          out_bad_nxt   = bad_r;
          out_ovf_nxt   = ovf_r;
          ovf_nxt       = 1'b0;
          l_ctl.clear   = 1'b1;
          r_ctl.clear   = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    li_r       <= li_nxt;
    ri_r       <= ri_nxt;
    bad_r      <= bad_nxt;
    zd_set_r   <= zd_set_nxt;
    zd_less_r  <= zd_less_nxt;
    dd_set_r   <= dd_set_nxt;
    dd_less_r  <= dd_less_nxt;
    res_less_r <= res_less_nxt;
    out_less_r <= out_less_nxt;
    out_bad_r  <= out_bad_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

endmodule

`default_nettype wire

[hw/rtl/nosc_checker.sv]
// Port-level checks for the natural order string compare core, bound to
// the top level. Depends on nosc_pkg, nosc_if and the assertion macros.
`default_nettype none

`include "natural_order_string_compare_core_assert.svh"

module nosc_checker (
  input logic        clk,
  input logic        rst_n,
  nosc_in_if.sink    in_ch,
  nosc_out_if.source out_ch
);
  import nosc_pkg::*;

  `NOSC_ASSERT_NEXT(a_out_hold, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.left_is_less) && $stable(out_ch.bad_char_seen) && $stable(out_ch.overflowed))
  `NOSC_ASSERT_NEXT(a_cmp_busy, in_ch.valid && in_ch.ready && (in_ch.cmd == CMD_CMP), !in_ch.ready)
  `NOSC_ASSERT(a_done_posts, $past(rst_n) && $rose(in_ch.ready) |-> out_ch.valid)
  `NOSC_ASSERT(a_post_on_done, $past(rst_n) && $rose(out_ch.valid) |-> $rose(in_ch.ready))

endmodule

bind natural_order_string_compare_core nosc_checker u_nosc_checker (
  .clk   (clk),
  .rst_n (rst_n),
  .in_ch (in_ch),
  .out_ch(out_ch)
);

`default_nettype wire
